[hdl/nhm_pkg.sv]
// shared types and constants for the nearest hit match unit
`default_nettype none
package nhm_pkg;

    localparam int POS_W               = 12;
    localparam int STATUS_W            = 3;
    localparam int TABLE_DEPTH_DEFAULT = 256;
    localparam int GROUP               = 16;

    typedef logic signed [POS_W-1:0] pos_t;

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_LOAD  = 2'd1,
        REQ_QUERY = 2'd2
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_CLEARED = 3'd0,
        ST_LOADED  = 3'd1,
        ST_MATCH   = 3'd2,
        ST_FULL    = 3'd3,
        ST_EMPTY   = 3'd4
    } status_t;

    // what a cell shows its neighbors
    typedef struct packed {
        pos_t val;
        logic occ;
        logic gt;
        logic lt;
    } link_t;

    // candidate words, zero where not hit so they can be or-reduced
    typedef struct packed {
        logic below_hit;
        logic above_hit;
        pos_t below_val;
        pos_t above_val;
    } cand_t;

endpackage
`default_nettype wire

[hdl/nhm_cell.sv]
// one table cell: holds a single sorted entry and flags nearest candidates
`default_nettype none
module nhm_cell (
    input  wire logic           clk,
    input  wire logic           load_en,
    input  wire logic           occ,
    input  wire nhm_pkg::pos_t  x,
    input  wire nhm_pkg::link_t prev,
    input  wire nhm_pkg::link_t next,
    output nhm_pkg::link_t      link,
    output nhm_pkg::cand_t      cand_reg
);

    nhm_pkg::pos_t  val_reg;
    nhm_pkg::pos_t  val_next;
    nhm_pkg::cand_t cand_next;
    logic           gt;
    logic           lt;

    always_comb
    begin
        gt = occ && (val_reg > x);
        lt = occ && (val_reg < x);

        // sorted insert: larger entries move up one cell
        val_next = val_reg;
        if (load_en)
        begin
            if (prev.gt)
            begin
                val_next = prev.val;
            end
            else if (gt || (!occ && prev.occ))
            begin
                val_next = x;
            end
        end

        // last entry below x, first entry at or above x
        cand_next.below_hit = lt && !next.lt;
        cand_next.above_hit = occ && !lt && prev.lt;
        cand_next.below_val = cand_next.below_hit ? val_reg : '0;
        cand_next.above_val = cand_next.above_hit ? val_reg : '0;
    end

    assign link.val = val_reg;
    assign link.occ = occ;
    assign link.gt  = gt;
    assign link.lt  = lt;

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        cand_reg <= cand_next;
    end

endmodule
`default_nettype wire

[hdl/nhm_or_stage.sv]
// one registered level of the candidate or-tree
`default_nettype none
module nhm_or_stage #(
    parameter int N_IN  = 256,
    parameter int N_OUT = 16
) (
    input  wire logic           clk,
    input  wire nhm_pkg::cand_t in_cand [N_IN],
    output nhm_pkg::cand_t      out_reg [N_OUT]
);

    genvar j;
    genvar k;

    generate
        for (j = 0; j < N_OUT; j++)
        begin : g_grp
            nhm_pkg::cand_t terms [nhm_pkg::GROUP];
            nhm_pkg::cand_t acc;

            for (k = 0; k < nhm_pkg::GROUP; k++)
            begin : g_term
                if (j * nhm_pkg::GROUP + k < N_IN)
                begin : g_used
                    assign terms[k] = in_cand[j * nhm_pkg::GROUP + k];
                end
                else
                begin : g_pad
                    assign terms[k] = '0;
                end
            end

            always_comb
            begin
                acc = '0;
                for (int m = 0; m < nhm_pkg::GROUP; m++)
                begin
                    acc = acc | terms[m];
                end
            end

            always_ff @(posedge clk)
            begin
                out_reg[j] <= acc;
            end
        end
    endgenerate

endmodule
`default_nettype wire

[hdl/nearest_hit_match_unit.sv]
// top level of the nearest hit match unit: request sequencer, cell row, or-tree
//
// usage
//   input channel  : in_valid / in_ready, beat = req_type + hit_x
//   output channel : out_valid / out_ready, beat = query_x + nearest_x + status
//   every beat with req_type 0, 1 or 2 gives exactly one output beat; code 3
//   is dropped with no output and no change of state
//   one request is worked on at a time; in_ready is high while the sequencer
//   is idle, even when a finished result still sits in the output register
//   a query on a filled table also passes the three registered levels of the
//   candidate or-tree (16 inputs per group) behind the cell row, stepped
//   through the states tree1, tree2 and tree3; clear, load, and a query on an
//   empty table go straight from the exec step to the result step; a load
//   shifts the whole row at once
//   reset clears the entry count, the sequencer and out_valid; the cells keep
//   whatever they held, entries at or above the count are never looked at
//   when the receiver stalls, the result waits in the sequencer's result step
//   and the output register holds its beat until it is taken
`default_nettype none
module nearest_hit_match_unit #(
    parameter int TABLE_DEPTH = nhm_pkg::TABLE_DEPTH_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [1:0]                    req_type,
    input  wire logic signed [nhm_pkg::POS_W-1:0] hit_x,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [nhm_pkg::POS_W-1:0]   query_x,
    output logic signed [nhm_pkg::POS_W-1:0]   nearest_x,
    output logic [nhm_pkg::STATUS_W-1:0]       status
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int L1_N  = (TABLE_DEPTH + nhm_pkg::GROUP - 1) / nhm_pkg::GROUP;
    localparam int L2_N  = (L1_N + nhm_pkg::GROUP - 1) / nhm_pkg::GROUP;
    localparam int L3_N  = (L2_N + nhm_pkg::GROUP - 1) / nhm_pkg::GROUP;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_TREE1,
        S_TREE2,
        S_TREE3,
        S_RESULT
    } state_t;

    state_t           state_reg;
    logic [1:0]       req_reg;
    nhm_pkg::pos_t    x_reg;
    logic [CNT_W-1:0] count_reg;
    nhm_pkg::status_t status_reg;
    logic             out_valid_reg;
    nhm_pkg::pos_t    query_x_reg;
    nhm_pkg::pos_t    nearest_x_reg;
    nhm_pkg::status_t status_out_reg;

    logic             full;
    logic             load_en;
    nhm_pkg::pos_t    pick;
    logic signed [nhm_pkg::POS_W:0] dist_below;
    logic signed [nhm_pkg::POS_W:0] dist_above;

    nhm_pkg::link_t links     [TABLE_DEPTH];
    nhm_pkg::cand_t cell_cand [TABLE_DEPTH];
    nhm_pkg::cand_t lvl1      [L1_N];
    nhm_pkg::cand_t lvl2      [L2_N];
    nhm_pkg::cand_t lvl3      [L3_N];
    nhm_pkg::link_t head_link;
    nhm_pkg::link_t tail_link;

    assign full    = (count_reg == CNT_W'(TABLE_DEPTH));
    assign load_en = (state_reg == S_EXEC) && (req_reg == nhm_pkg::REQ_LOAD) && !full;

    // cell 0 sees an occupied, all-below neighbor; the last cell sees an empty one
    assign head_link = '{val: '0, occ: 1'b1, gt: 1'b0, lt: 1'b1};
    assign tail_link = '{val: '0, occ: 1'b0, gt: 1'b0, lt: 1'b0};

    // cell row
    genvar i;
    generate
        for (i = 0; i < TABLE_DEPTH; i++)
        begin : g_cell
            nhm_pkg::link_t prev_link;
            nhm_pkg::link_t next_link;
            logic           occ;

            assign occ = (count_reg > CNT_W'(i));

            if (i == 0)
            begin : g_first
                assign prev_link = head_link;
            end
            else
            begin : g_mid_prev
                assign prev_link = links[i-1];
            end

            if (i == TABLE_DEPTH - 1)
            begin : g_last
                assign next_link = tail_link;
            end
            else
            begin : g_mid_next
                assign next_link = links[i+1];
            end

            nhm_cell u_cell (
                .clk      (clk),
                .load_en  (load_en),
                .occ      (occ),
                .x        (x_reg),
                .prev     (prev_link),
                .next     (next_link),
                .link     (links[i]),
                .cand_reg (cell_cand[i])
            );
        end
    endgenerate

    // registered or-tree gathering the two candidates
    nhm_or_stage #(.N_IN(TABLE_DEPTH), .N_OUT(L1_N)) u_lvl1 (
        .clk     (clk),
        .in_cand (cell_cand),
        .out_reg (lvl1)
    );

    nhm_or_stage #(.N_IN(L1_N), .N_OUT(L2_N)) u_lvl2 (
        .clk     (clk),
        .in_cand (lvl1),
        .out_reg (lvl2)
    );

    nhm_or_stage #(.N_IN(L2_N), .N_OUT(L3_N)) u_lvl3 (
        .clk     (clk),
        .in_cand (lvl2),
        .out_reg (lvl3)
    );

    // nearest pick, lower entry wins a tie
    always_comb
    begin
        dist_below = {x_reg[nhm_pkg::POS_W-1], x_reg}
                   - {lvl3[0].below_val[nhm_pkg::POS_W-1], lvl3[0].below_val};
        dist_above = {lvl3[0].above_val[nhm_pkg::POS_W-1], lvl3[0].above_val}
                   - {x_reg[nhm_pkg::POS_W-1], x_reg};
        if (!lvl3[0].below_hit)
        begin
            pick = lvl3[0].above_val;
        end
        else if (!lvl3[0].above_hit)
        begin
            pick = lvl3[0].below_val;
        end
        else if (dist_below <= dist_above)
        begin
            pick = lvl3[0].below_val;
        end
        else
        begin
            pick = lvl3[0].above_val;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign query_x   = query_x_reg;
    assign nearest_x = nearest_x_reg;
    assign status    = status_out_reg;

    // request sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            req_reg        <= '0;
            x_reg          <= '0;
            count_reg      <= '0;
            status_reg     <= nhm_pkg::ST_CLEARED;
            out_valid_reg  <= 1'b0;
            query_x_reg    <= '0;
            nearest_x_reg  <= '0;
            status_out_reg <= nhm_pkg::ST_CLEARED;
        end
        else
        begin
            // the result step reloads the output register itself
            if (out_valid_reg && out_ready && (state_reg != S_RESULT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg   <= req_type;
                        x_reg     <= hit_x;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    unique case (req_reg)
                        nhm_pkg::REQ_CLEAR:
                        begin
                            count_reg  <= '0;
                            status_reg <= nhm_pkg::ST_CLEARED;
                            state_reg  <= S_RESULT;
                        end
                        nhm_pkg::REQ_LOAD:
                        begin
                            if (full)
                            begin
                                status_reg <= nhm_pkg::ST_FULL;
                            end
                            else
                            begin
                                count_reg  <= count_reg + 1'b1;
                                status_reg <= nhm_pkg::ST_LOADED;
                            end
                            state_reg <= S_RESULT;
                        end
                        nhm_pkg::REQ_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                status_reg <= nhm_pkg::ST_EMPTY;
                                state_reg  <= S_RESULT;
                            end
                            else
                            begin
                                status_reg <= nhm_pkg::ST_MATCH;
                                state_reg  <= S_TREE1;
                            end
                        end
                        default:
                        begin
                            // unused code: no beat, no change
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_TREE1:
                begin
                    state_reg <= S_TREE2;
                end
                S_TREE2:
                begin
                    state_reg <= S_TREE3;
                end
                S_TREE3:
                begin
                    state_reg <= S_RESULT;
                end
                S_RESULT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        query_x_reg    <= x_reg;
                        nearest_x_reg  <= (status_reg == nhm_pkg::ST_MATCH) ? pick : '0;
                        status_out_reg <= status_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // entry count never passes the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    // a load into a full table leaves the count alone
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && req_reg == nhm_pkg::REQ_LOAD && full)
        |=> (count_reg == $past(count_reg)))
        else $error("dropped load changed the entry count");

    // a match result always has at least one candidate from the tree
    a_match_cand: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && status_reg == nhm_pkg::ST_MATCH)
        |-> (lvl3[0].below_hit || lvl3[0].above_hit))
        else $error("match without candidate");

    // a new output beat only comes from the result step
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RESULT))
        else $error("output beat outside result step");

endmodule
`default_nettype wire
